// ===== rtl/core/sbcf_pkg.sv =====
// ----------------------------------------------------------------------------
// sbcf_pkg
// Shared types, register indexes and the cosine ease table generator for the
// status blink code fader.
// ----------------------------------------------------------------------------
package sbcf_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_LED_ENABLE  = 3'd0,
		REG_BRIGHTNESS  = 3'd1,
		REG_REPEAT_MS   = 3'd2,
		REG_SLOT_MS     = 3'd3,
		REG_FADE_IN_MS  = 3'd4,
		REG_HOLD_MS     = 3'd5,
		REG_FADE_OUT_MS = 3'd6
	} reg_idx_t;

	localparam logic [15:0] RST_REPEAT_MS   = 16'd3000;
	localparam logic [15:0] RST_SLOT_MS     = 16'd400;
	localparam logic [15:0] RST_FADE_IN_MS  = 16'd120;
	localparam logic [15:0] RST_HOLD_MS     = 16'd80;
	localparam logic [15:0] RST_FADE_OUT_MS = 16'd120;

	// Q1.15 full scale and rounding half.
	localparam logic [15:0] Q15_ONE  = 16'h8000;
	localparam logic [15:0] Q15_HALF = 16'h4000;

	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef struct packed {
		logic        led_enable;
		logic [7:0]  brightness;
		logic [15:0] repeat_ms;
		logic [15:0] slot_ms;
		logic [15:0] fade_in_ms;
		logic [15:0] hold_ms;
		logic [15:0] fade_out_ms;
	} cfg_t;

	// Which quantity the shared divider works on.
	typedef enum logic [1:0] {
		DIV_ROLL = 2'd0,
		DIV_SLOT = 2'd1,
		DIV_RISE = 2'd2,
		DIV_FALL = 2'd3
	} div_op_t;

	typedef struct packed {
		logic    load_in;
		logic    div_start;
		div_op_t div_op;
		logic    take_roll;
		logic    take_elapsed;
		logic    take_pos;
		logic    take_hold;
		logic    take_idx;
		logic    take_factor;
		logic    lvl_mul;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic dark;
		logic roll_need;
		logic in_window;
		logic past_pulse;
		logic in_rise;
		logic in_hold;
		logic div_done;
	} dp_status_t;

	// Prioritised blink count from the link flags.
	function automatic logic [2:0] pulse_count(input logic wifi_up, input logic broker_enabled,
			input logic broker_up, input logic device_up);
		logic [2:0] cnt;
		if (!wifi_up) begin
			cnt = 3'd4;
		end else if (broker_enabled && !broker_up) begin
			cnt = 3'd3;
		end else if (!device_up) begin
			cnt = 3'd2;
		end else begin
			cnt = 3'd1;
		end
		return cnt;
	endfunction

	// Sine of a Q30 angle in [0, pi/4] by a nested Taylor series.
	function automatic logic [63:0] sin_q30(input logic [63:0] t);
		logic [63:0] t2;
		logic [63:0] term;
		t2   = (t * t) >> 30;
		term = Q30_ONE;
		term = Q30_ONE - (((t2 * term) >> 30) / 64'd110);
		term = Q30_ONE - (((t2 * term) >> 30) / 64'd72);
		term = Q30_ONE - (((t2 * term) >> 30) / 64'd42);
		term = Q30_ONE - (((t2 * term) >> 30) / 64'd20);
		term = Q30_ONE - (((t2 * term) >> 30) / 64'd6);
		return (t * term) >> 30;
	endfunction

	// Lower half of the ease table: round(32768 * sin^2(pi*i/(2N))), N = 2^index_bits.
	// Evaluated at elaboration only.
	function automatic logic [15:0] ease_low_half(input int unsigned i,
			input int unsigned index_bits);
		logic [63:0] t;
		logic [63:0] s;
		t = (HALF_PI_Q30 * 64'(i)) >> index_bits;
		s = sin_q30(t);
		return 16'((s * s + (64'd1 << 44)) >> 45);
	endfunction

endpackage

// ===== rtl/core/sbcf_div.sv =====
// ----------------------------------------------------------------------------
// sbcf_div
// Restoring divider, one quotient bit per cycle, 16-bit divisor.
// ----------------------------------------------------------------------------
module sbcf_div #(
	parameter int DIV_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [15:0]      divisor,
	output logic [DIV_W-1:0] quotient,
	output logic [15:0]      remainder,
	output logic             done
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] dvd_q;
	logic [15:0]      rem_q;
	logic [15:0]      dsr_q;

	logic [16:0] trial;
	logic [16:0] diff;
	logic        fits;

	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[15:0] : trial[15:0];
			dvd_q <= {dvd_q[DIV_W-2:0], fits};
		end
	end

	assign quotient  = dvd_q;
	assign remainder = rem_q;
	assign done      = done_q;

endmodule

// ===== rtl/core/sbcf_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbcf_ctrl
// Sequencer for one tick: period rollover, slot position, ease lookup, level.
// ----------------------------------------------------------------------------
module sbcf_ctrl
	import sbcf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t st,
	output dp_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROLL,
		ST_ROLL_WAIT,
		ST_WIN,
		ST_SLOT_WAIT,
		ST_PHASE,
		ST_EASE_WAIT,
		ST_LOOKUP,
		ST_MUL,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = st.dark ? ST_FINISH : ST_ROLL;
				end
			end
			ST_ROLL: begin
				if (st.roll_need) begin
					cmd.div_start = 1'b1;
					cmd.div_op    = DIV_ROLL;
					state_d       = ST_ROLL_WAIT;
				end else begin
					cmd.take_elapsed = 1'b1;
					state_d          = ST_WIN;
				end
			end
			ST_ROLL_WAIT: begin
				if (st.div_done) begin
					cmd.take_roll = 1'b1;
					state_d       = ST_WIN;
				end
			end
			ST_WIN: begin
				if (st.in_window) begin
					cmd.div_start = 1'b1;
					cmd.div_op    = DIV_SLOT;
					state_d       = ST_SLOT_WAIT;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_SLOT_WAIT: begin
				if (st.div_done) begin
					cmd.take_pos = 1'b1;
					state_d      = ST_PHASE;
				end
			end
			ST_PHASE: begin
				priority if (st.past_pulse) begin
					state_d = ST_FINISH;
				end else if (st.in_rise) begin
					cmd.div_start = 1'b1;
					cmd.div_op    = DIV_RISE;
					state_d       = ST_EASE_WAIT;
				end else if (st.in_hold) begin
					cmd.take_hold = 1'b1;
					state_d       = ST_MUL;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_op    = DIV_FALL;
					state_d       = ST_EASE_WAIT;
				end
			end
			ST_EASE_WAIT: begin
				if (st.div_done) begin
					cmd.take_idx = 1'b1;
					state_d      = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				cmd.take_factor = 1'b1;
				state_d         = ST_MUL;
			end
			ST_MUL: begin
				cmd.lvl_mul = 1'b1;
				state_d     = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/sbcf_datapath.sv =====
// ----------------------------------------------------------------------------
// sbcf_datapath
// Cycle state, slot arithmetic, ease table, level multiply and result word.
// ----------------------------------------------------------------------------
module sbcf_datapath
	import sbcf_pkg::*;
#(
	parameter int EASE_INDEX_BITS = 8,
	parameter int TIME_WIDTH      = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        cycle_clear,
	input  logic [31:0] now_ms,
	input  logic        wifi_up,
	input  logic        broker_enabled,
	input  logic        broker_up,
	input  logic        device_up,
	input  dp_cmd_t     cmd,
	output dp_status_t  st,
	output logic [7:0]  led_level,
	output logic [2:0]  pulses_in_cycle
);

	localparam int DIV_W  = (TIME_WIDTH > 16 + EASE_INDEX_BITS) ?
		TIME_WIDTH : 16 + EASE_INDEX_BITS;
	localparam int EASE_N = 1 << EASE_INDEX_BITS;
	localparam int HALF   = EASE_N / 2;
	localparam int IDX_W  = EASE_INDEX_BITS + 1;

	// Lower half of the ease curve; the upper half is its mirror image.
	logic [15:0] ease_lo [HALF+1];

	for (genvar g = 0; g <= HALF; g++) begin : g_ease
		localparam logic [15:0] ENTRY = ease_low_half(g, EASE_INDEX_BITS);
		assign ease_lo[g] = ENTRY;
	end

	logic [TIME_WIDTH-1:0] now_q;
	logic [TIME_WIDTH-1:0] start_q;
	logic [2:0]            count_q;
	logic [2:0]            pulses_q;
	logic                  valid_q;
	logic [15:0]           elapsed_q;
	logic [15:0]           pos_q;
	logic                  fall_q;
	logic [IDX_W-1:0]      idx_q;
	logic [15:0]           factor_q;
	logic [7:0]            level_q;
	logic [7:0]            led_level_q;
	logic [2:0]            pulses_out_q;

	logic [TIME_WIDTH-1:0] now_in;
	logic [2:0]            count_in;
	logic                  dark;
	logic [15:0]           period;
	logic [TIME_WIDTH-1:0] elapsed_full;
	logic [18:0]           window_len;
	logic [17:0]           pulse_len;
	logic [16:0]           hold_end;
	logic [15:0]           fall_off;
	logic [DIV_W-1:0]      div_dvd;
	logic [15:0]           div_dsr;
	logic [DIV_W-1:0]      div_quot;
	logic [15:0]           div_rem;
	logic                  div_done;
	logic [IDX_W-1:0]      mirror;
	logic [15:0]           ease_val;
	logic [23:0]           prod;

	assign now_in       = now_ms[TIME_WIDTH-1:0];
	assign count_in     = pulse_count(wifi_up, broker_enabled, broker_up, device_up);
	assign dark         = !cfg.led_enable || (cfg.brightness == 8'd0);
	assign period       = (cfg.repeat_ms == 16'd0) ? 16'd1 : cfg.repeat_ms;
	assign elapsed_full = now_q - start_q;
	assign window_len   = 19'(pulses_q) * 19'(cfg.slot_ms);
	assign pulse_len    = 18'(cfg.fade_in_ms) + 18'(cfg.hold_ms) + 18'(cfg.fade_out_ms);
	assign hold_end     = 17'(cfg.fade_in_ms) + 17'(cfg.hold_ms);
	assign fall_off     = pos_q - cfg.fade_in_ms - cfg.hold_ms;

	assign st.dark       = dark;
	assign st.roll_need  = elapsed_full >= TIME_WIDTH'(period);
	assign st.in_window  = 19'(elapsed_q) < window_len;
	assign st.past_pulse = 18'(pos_q) >= pulse_len;
	assign st.in_rise    = pos_q < cfg.fade_in_ms;
	assign st.in_hold    = 17'(pos_q) < hold_end;
	assign st.div_done   = div_done;

	always_comb begin
		unique case (cmd.div_op)
			DIV_ROLL: begin
				div_dvd = DIV_W'(elapsed_full);
				div_dsr = period;
			end
			DIV_SLOT: begin
				div_dvd = DIV_W'(elapsed_q);
				div_dsr = cfg.slot_ms;
			end
			DIV_RISE: begin
				div_dvd = DIV_W'(pos_q) << EASE_INDEX_BITS;
				div_dsr = cfg.fade_in_ms;
			end
			DIV_FALL: begin
				div_dvd = DIV_W'(fall_off) << EASE_INDEX_BITS;
				div_dsr = cfg.fade_out_ms;
			end
			default: begin
				div_dvd = '0;
				div_dsr = 16'd1;
			end
		endcase
	end

	sbcf_div #(
		.DIV_W(DIV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.quotient (div_quot),
		.remainder(div_rem),
		.done     (div_done)
	);

	// Ease lookup with the upper half mirrored about the midpoint.
	assign mirror   = IDX_W'(EASE_N) - idx_q;
	assign ease_val = (idx_q <= IDX_W'(HALF)) ? ease_lo[idx_q[EASE_INDEX_BITS-1:0]] :
		Q15_ONE - ease_lo[mirror[EASE_INDEX_BITS-1:0]];

	assign prod = 24'(cfg.brightness) * 24'(factor_q) + 24'(Q15_HALF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulses_q <= 3'd0;
			valid_q  <= 1'b0;
		end else if (cycle_clear) begin
			pulses_q <= 3'd0;
			valid_q  <= 1'b0;
		end else if (cmd.load_in && !dark && !valid_q) begin
			pulses_q <= count_in;
			valid_q  <= 1'b1;
		end else if (cmd.take_roll) begin
			pulses_q <= count_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			now_q   <= now_in;
			count_q <= count_in;
			level_q <= 8'd0;
			if (!dark && !valid_q) begin
				start_q <= now_in;
			end
		end
		if (cmd.take_roll) begin
			start_q   <= now_q - TIME_WIDTH'(div_rem);
			elapsed_q <= div_rem;
		end
		if (cmd.take_elapsed) begin
			elapsed_q <= elapsed_full[15:0];
		end
		if (cmd.take_pos) begin
			pos_q <= div_rem;
		end
		if (cmd.div_start) begin
			fall_q <= (cmd.div_op == DIV_FALL);
		end
		if (cmd.take_idx) begin
			idx_q <= (div_quot > DIV_W'(EASE_N)) ? IDX_W'(EASE_N) : div_quot[IDX_W-1:0];
		end
		if (cmd.take_hold) begin
			factor_q <= Q15_ONE;
		end
		if (cmd.take_factor) begin
			factor_q <= fall_q ? Q15_ONE - ease_val : ease_val;
		end
		if (cmd.lvl_mul) begin
			level_q <= prod[22:15];
		end
		if (cmd.out_load) begin
			led_level_q  <= level_q;
			pulses_out_q <= pulses_q;
		end
	end

	assign led_level       = led_level_q;
	assign pulses_in_cycle = pulses_out_q;

endmodule

// ===== rtl/core/status_blink_code_fader.sv =====
// ----------------------------------------------------------------------------
// status_blink_code_fader
// Each input word is one millisecond tick with the link flags; each result
// word is the LED level for that tick and the blink count of the current
// repeat period. At the start of every repeat period the count is latched
// from the flags (no wireless gives 4, broker enabled but down gives 3,
// device down gives 2, otherwise 1), and each slot of the period shows one
// pulse that rises on a cosine ease, holds at the set brightness and falls
// again. With the LED disabled or brightness zero the level is zero and the
// cycle state is kept. Rewriting led_enable with a new value restarts the
// cycle. A dark tick goes from acceptance straight to the result hand-off;
// otherwise it passes through up to three divisions on the shared
// restoring divider of width DIV_W (period rollover, slot position, ease
// index), where DIV_W is the larger of TIME_WIDTH and 16 + EASE_INDEX_BITS,
// then, as needed, through lookup, multiply and hand-off. A new tick is
// accepted while the previous result word still waits at the output.
// ----------------------------------------------------------------------------
module status_blink_code_fader
	import sbcf_pkg::*;
#(
	parameter int EASE_INDEX_BITS = 8,
	parameter int TIME_WIDTH      = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [31:0]            now_ms,
	input  logic                   wifi_up,
	input  logic                   broker_enabled,
	input  logic                   broker_up,
	input  logic                   device_up,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             led_level,
	output logic [2:0]             pulses_in_cycle
);

	cfg_t       cfg_q;
	logic       cycle_clear;
	dp_cmd_t    cmd;
	dp_status_t st;

	// Changing led_enable, and only changing it, drops the running cycle.
	assign cycle_clear = cfg_we && (cfg_index == REG_LED_ENABLE) &&
		(cfg_wdata[0] != cfg_q.led_enable);

	// Configuration registers. The user must write them only while no word is in
	// flight, so the sequencer never sees them change under it; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.led_enable  <= 1'b0;
			cfg_q.brightness  <= 8'd0;
			cfg_q.repeat_ms   <= RST_REPEAT_MS;
			cfg_q.slot_ms     <= RST_SLOT_MS;
			cfg_q.fade_in_ms  <= RST_FADE_IN_MS;
			cfg_q.hold_ms     <= RST_HOLD_MS;
			cfg_q.fade_out_ms <= RST_FADE_OUT_MS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LED_ENABLE:  cfg_q.led_enable  <= cfg_wdata[0];
				REG_BRIGHTNESS:  cfg_q.brightness  <= cfg_wdata[7:0];
				REG_REPEAT_MS:   cfg_q.repeat_ms   <= cfg_wdata;
				REG_SLOT_MS:     cfg_q.slot_ms     <= cfg_wdata;
				REG_FADE_IN_MS:  cfg_q.fade_in_ms  <= cfg_wdata;
				REG_HOLD_MS:     cfg_q.hold_ms     <= cfg_wdata;
				REG_FADE_OUT_MS: cfg_q.fade_out_ms <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// The sequencer steps one tick through its divisions and the datapath
	// carries the cycle state and the arithmetic.
	sbcf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.st       (st),
		.cmd      (cmd)
	);

	sbcf_datapath #(
		.EASE_INDEX_BITS(EASE_INDEX_BITS),
		.TIME_WIDTH     (TIME_WIDTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.cycle_clear    (cycle_clear),
		.now_ms         (now_ms),
		.wifi_up        (wifi_up),
		.broker_enabled (broker_enabled),
		.broker_up      (broker_up),
		.device_up      (device_up),
		.cmd            (cmd),
		.st             (st),
		.led_level      (led_level),
		.pulses_in_cycle(pulses_in_cycle)
	);

`ifndef SYNTHESIS
	// A dark LED always produces a zero level.
	a_dark_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (led_level == 8'd0) ||
		($past(cfg_q.led_enable) && ($past(cfg_q.brightness) != 8'd0)))
		else $error("nonzero level while LED is dark");

	// The level never exceeds the programmed peak.
	a_level_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> led_level <= $past(cfg_q.brightness))
		else $error("level above brightness");

	// The latched blink count stays within its range.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pulses_in_cycle <= 3'd4)
		else $error("pulse count out of range");
`endif

endmodule
